// ----- rtl/core/cplt_pkg.sv -----
// Shared types and constants for the carrier prefix table.
`timescale 1ns / 1ps

package cplt_pkg;

   localparam int PREFIX_ENTRIES = 16;
   localparam int COUNT_W        = $clog2(PREFIX_ENTRIES + 1);
   localparam int ADDR_W         = 32;
   localparam int CARRIER_W      = 8;

   typedef enum logic [1:0] {
      ACTION_LOOKUP = 2'd0,
      ACTION_ADD    = 2'd1,
      ACTION_FLUSH  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_SEARCH
   } state_type;

   // Per-cell control from the table controller.
   typedef struct packed {
      logic live;    // cell holds an entry below the fill count
      logic write;   // load the entry offered on the write bus
   } cell_ctrl_type;

   typedef struct packed {
      logic [ADDR_W-1:0]    network;
      logic [ADDR_W-1:0]    mask;
      logic [CARRIER_W-1:0] carrier;
   } entry_type;

   // Lookup in flight along the row of cells.
   typedef struct packed {
      logic                 valid;
      logic [ADDR_W-1:0]    addr;
      logic [ADDR_W-1:0]    best;
      logic [CARRIER_W-1:0] answer;
   } token_type;

endpackage

// ----- rtl/core/cplt_cell.sv -----
// One table entry with its stage of the lookup walk.
`timescale 1ns / 1ps

module cplt_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  cplt_pkg::cell_ctrl_type ctrl,
   input  cplt_pkg::entry_type    wr_entry,
   input  cplt_pkg::token_type    tok_in,
   output cplt_pkg::token_type    tok_out
);
   import cplt_pkg::*;

   entry_type entry_ff;
   token_type tok_ff;
   token_type tok_in_next;
   logic      hit;

   // A later entry wins on equal masks, hence the greater-or-equal compare.
   assign hit = ctrl.live && ((tok_in.addr & entry_ff.mask) == entry_ff.network) &&
                (entry_ff.mask >= tok_in.best);

   always_comb begin
      tok_in_next = tok_in;
      if (hit) begin
         tok_in_next.best   = entry_ff.mask;
         tok_in_next.answer = entry_ff.carrier;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.write) begin
         entry_ff <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.addr   <= tok_in_next.addr;
      tok_ff.best   <= tok_in_next.best;
      tok_ff.answer <= tok_in_next.answer;
   end

   assign tok_out = tok_ff;

endmodule

// ----- rtl/core/carrier_prefix_lpm_table.sv -----
// Top level of the carrier prefix table: controller and row of entry cells.
`timescale 1ns / 1ps

// Longest-prefix table of PREFIX_ENTRIES entries, one entry per cell in a row.
// An add or flush item is finished at once, and a lookup walks the row one cell
// per cycle. A new item is taken only when the table is idle and the pending
// stage is empty. One item is worked on at a time, while a finished result may
// still wait in the output register. The no-match carrier may be written at any
// time the table is idle; the write port is always ready.
module carrier_prefix_lpm_table (
   input  logic        clock,
   input  logic        reset,
   // Request item.
   input  logic        req_tvalid,
   output logic        req_tready,
   // [31:0] lookup_address, [63:32] prefix_network, [95:64] prefix_mask,
   // [103:96] carrier_tag
   input  logic [103:0] req_tdata,
   // [1:0] action
   input  logic [1:0]  req_tuser,
   // Response item.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] carrier
   output logic [7:0]  rsp_tdata,
   // [1:0] status
   output logic [1:0]  rsp_tuser,
   // No-match carrier register write.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);
   import cplt_pkg::*;

   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [CARRIER_W-1:0] no_match_ff;

   logic                 pend_valid_ff, pend_valid_in;
   logic [CARRIER_W-1:0] pend_carrier_ff, pend_carrier_in;
   status_type           pend_status_ff, pend_status_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CARRIER_W-1:0] rsp_carrier_ff;
   status_type           rsp_status_ff;

   logic                 accept;
   logic                 launch;
   logic                 add_ok;
   logic                 pend_load;
   logic                 pend_move;
   logic                 table_full;
   status_type           cmd_status;
   action_type           action;

   logic [ADDR_W-1:0]    lookup_address;
   logic [ADDR_W-1:0]    prefix_network;
   logic [ADDR_W-1:0]    prefix_mask;
   logic [CARRIER_W-1:0] carrier_tag;

   entry_type            wr_entry;
   cell_ctrl_type        ctrl [PREFIX_ENTRIES];
   token_type            tok [PREFIX_ENTRIES+1];

   assign lookup_address = req_tdata[31:0];
   assign prefix_network = req_tdata[63:32];
   assign prefix_mask    = req_tdata[95:64];
   assign carrier_tag    = req_tdata[103:96];
   assign action         = action_type'(req_tuser);

   assign accept     = req_tvalid && req_tready;
   assign table_full = (count_ff == COUNT_W'(PREFIX_ENTRIES));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (launch) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (tok[PREFIX_ENTRIES].valid) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Controller outputs.
   always_comb begin
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_tready = !pend_valid_ff;
         ST_SEARCH: req_tready = 1'b0;
         default:   req_tready = 1'b0;
      endcase
   end

   assign launch = accept && (action == ACTION_LOOKUP);

   // Add, flush and unused actions finish at once.
   always_comb begin
      cmd_status = STATUS_OK;
      add_ok     = 1'b0;
      count_in   = count_ff;
      unique case (action)
         ACTION_LOOKUP: cmd_status = STATUS_OK;
         ACTION_ADD: begin
            if ((prefix_mask == '0) || (carrier_tag == '0)) begin
               cmd_status = STATUS_INVALID;
            end else if (table_full) begin
               cmd_status = STATUS_FULL;
            end else begin
               add_ok = accept;
               if (accept) begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         ACTION_FLUSH: begin
            if (accept) begin
               count_in = '0;
            end
         end
         default: cmd_status = STATUS_INVALID;
      endcase
   end

   assign wr_entry.network = prefix_network & prefix_mask;
   assign wr_entry.mask    = prefix_mask;
   assign wr_entry.carrier = carrier_tag;

   assign tok[0].valid  = launch;
   assign tok[0].addr   = lookup_address;
   assign tok[0].best   = '0;
   assign tok[0].answer = no_match_ff;

   for (genvar i = 0; i < PREFIX_ENTRIES; i++) begin : g_cell
      assign ctrl[i].live  = (count_ff > COUNT_W'(i));
      assign ctrl[i].write = add_ok && (count_ff == COUNT_W'(i));

      cplt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl[i]),
         .wr_entry (wr_entry),
         .tok_in   (tok[i]),
         .tok_out  (tok[i+1])
      );
   end

   // The pending stage holds a finished result until the output register frees.
   assign pend_load = (accept && !launch) || tok[PREFIX_ENTRIES].valid;
   assign pend_move = pend_valid_ff && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      pend_valid_in   = pend_valid_ff;
      pend_carrier_in = pend_carrier_ff;
      pend_status_in  = pend_status_ff;
      if (pend_load) begin
         pend_valid_in = 1'b1;
         if (tok[PREFIX_ENTRIES].valid) begin
            pend_carrier_in = tok[PREFIX_ENTRIES].answer;
            pend_status_in  = STATUS_OK;
         end else begin
            pend_carrier_in = '0;
            pend_status_in  = cmd_status;
         end
      end else if (pend_move) begin
         pend_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pend_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         no_match_ff   <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            no_match_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_carrier_ff <= pend_carrier_in;
      pend_status_ff  <= pend_status_in;
      if (pend_move) begin
         rsp_carrier_ff <= pend_carrier_ff;
         rsp_status_ff  <= pend_status_ff;
      end
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_carrier_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ----- rtl/core/cplt_checker.sv -----
// Port-level checks for the carrier prefix table, bound to the top level.
`timescale 1ns / 1ps

module cplt_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [1:0] rsp_tuser
);
   import cplt_pkg::*;

   // A stalled response item holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response item changed while stalled");

   // Only the three defined status codes appear.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == STATUS_OK) || (rsp_tuser == STATUS_INVALID) ||
                     (rsp_tuser == STATUS_FULL))
      else $error("undefined status code");

   // A failed command never carries a carrier.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != STATUS_OK) |-> (rsp_tdata == '0))
      else $error("carrier on a failed item");

   // Reset empties the response register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind carrier_prefix_lpm_table cplt_checker u_cplt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ----- dv/tb_top.sv -----
// Testbench for the carrier prefix table: directed and random items checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
   import cplt_pkg::*;

   // The action field is two bits wide, so the fourth code must be exercised too.
   localparam logic [1:0] ACTION_UNUSED = 2'd3;
   localparam int LIMIT_CYCLES = 400000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 2 * PREFIX_ENTRIES + 8;
   localparam int PHASE_ITEMS  = 140;
   localparam int MAX_REPORTS  = 10;

   typedef struct {
      logic [1:0]  action;
      logic [31:0] addr;
      logic [31:0] net;
      logic [31:0] mask;
      logic [7:0]  tag;
   } req_item_type;

   typedef struct {
      logic [7:0] carrier;
      logic [1:0] status;
   } rsp_item_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [7:0]   rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [7:0]   csr_data = '0;

   carrier_prefix_lpm_table u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Predicted table contents and no-match carrier.
   logic [31:0] tbl_net     [PREFIX_ENTRIES];
   logic [31:0] tbl_mask    [PREFIX_ENTRIES];
   logic [7:0]  tbl_carrier [PREFIX_ENTRIES];
   int          tbl_count    = 0;
   logic [7:0]  miss_carrier = '0;

   req_item_type req_backlog[$];
   rsp_item_type expected_rsp[$];
   req_item_type cur_req;
   rsp_item_type mon_want;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          mismatches    = 0;
   int          rsp_seen      = 0;
   int          pushed        = 0;
   int          issued        = 0;
   int          hold_req      = 0;
   int          hold_served   = 0;
   int          hold_left     = 0;
   int          cycle_count   = 0;

   // Networks and masks added since the last flush, used to aim lookups at entries.
   logic [31:0] gen_net[$];
   logic [31:0] gen_mask[$];

   function automatic rsp_item_type lpm_predict(req_item_type it);
      rsp_item_type r;
      logic [31:0] best;
      r.carrier = '0;
      r.status  = STATUS_OK;
      best      = '0;
      case (it.action)
         ACTION_LOOKUP: begin
            r.carrier = miss_carrier;
            // Greater-or-equal lets a later entry win a tie on the mask.
            for (int i = 0; i < tbl_count; i++) begin
               if ((it.addr & tbl_mask[i]) == tbl_net[i] && tbl_mask[i] >= best) begin
                  best      = tbl_mask[i];
                  r.carrier = tbl_carrier[i];
               end
            end
         end
         ACTION_ADD: begin
            if (it.mask == '0 || it.tag == '0) begin
               r.status = STATUS_INVALID;
            end else if (tbl_count >= PREFIX_ENTRIES) begin
               r.status = STATUS_FULL;
            end else begin
               tbl_net[tbl_count]     = it.net & it.mask;
               tbl_mask[tbl_count]    = it.mask;
               tbl_carrier[tbl_count] = it.tag;
               tbl_count++;
            end
         end
         ACTION_FLUSH: begin
            tbl_count = 0;
         end
         default: begin
            r.status = STATUS_INVALID;
         end
      endcase
      return r;
   endfunction

   function automatic logic [31:0] prefix_mask(int len);
      if (len == 0)
         return '0;
      return 32'hFFFF_FFFF << (32 - len);
   endfunction

   task automatic push_req(logic [1:0] action, logic [31:0] addr, logic [31:0] net,
                           logic [31:0] mask, logic [7:0] tag);
      req_item_type it;
      it.action = action;
      it.addr   = addr;
      it.net    = net;
      it.mask   = mask;
      it.tag    = tag;
      req_backlog.push_back(it);
      pushed++;
      issued++;
   endtask

   // One sequence: mostly flush, a run of adds and lookups aimed at them; sometimes noise.
   task automatic gen_sequence();
      int          n_add;
      int          n_look;
      int          pick;
      logic [31:0] m;
      logic [31:0] a;
      logic [7:0]  tag;
      if ($urandom_range(99) < 20) begin
         push_req(2'($urandom_range(3)), $urandom, $urandom, $urandom,
                  8'($urandom_range(255)));
         return;
      end
      if ($urandom_range(3) != 0) begin
         push_req(ACTION_FLUSH, $urandom, $urandom, $urandom, 8'($urandom_range(255)));
         gen_net.delete();
         gen_mask.delete();
      end
      n_add = ($urandom_range(9) == 0) ? $urandom_range(14, 19) : $urandom_range(0, 6);
      for (int i = 0; i < n_add; i++) begin
         a = $urandom;
         case ($urandom_range(9))
            0: m = $urandom;
            1: begin
               // Same prefix as an earlier entry, so the later one must win.
               if (gen_mask.size() > 0) begin
                  pick = $urandom_range(gen_mask.size() - 1);
                  m = gen_mask[pick];
                  a = gen_net[pick] | ($urandom & ~m);
               end else begin
                  m = $urandom;
               end
            end
            default: m = prefix_mask($urandom_range(32));
         endcase
         tag = ($urandom_range(19) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
         push_req(ACTION_ADD, $urandom, a, m, tag);
         gen_net.push_back(a & m);
         gen_mask.push_back(m);
      end
      n_look = $urandom_range(1, 6);
      for (int i = 0; i < n_look; i++) begin
         if (gen_net.size() > 0 && $urandom_range(3) != 0) begin
            pick = $urandom_range(gen_net.size() - 1);
            a = gen_net[pick] | ($urandom & ~gen_mask[pick]);
         end else begin
            a = $urandom;
         end
         push_req(ACTION_LOOKUP, a, $urandom, $urandom, 8'($urandom_range(255)));
      end
   endtask

   // Every item queued so far has had its response taken.
   task automatic wait_idle();
      while (rsp_seen < issued)
         @(posedge clock);
   endtask

   task automatic write_miss_carrier(logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid    <= 1'b0;
      miss_carrier = value;
   endtask

   // Request driver: an offered item stays on the bus until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_rsp.push_back(lpm_predict(cur_req));
         if (!req_tvalid || req_tready) begin
            if (req_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_req = req_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {cur_req.tag, cur_req.mask, cur_req.net, cur_req.addr};
               req_tuser  <= cur_req.action;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response ready, with a long hold-off whenever the stimulus asks for one.
   always @(posedge clock) begin
      if (hold_req != hold_served) begin
         hold_served = hold_req;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_seen++;
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("response %0d with no item pending: carrier %02h status %0d",
                        rsp_seen, rsp_tdata, rsp_tuser);
         end else begin
            mon_want = expected_rsp.pop_front();
            if (rsp_tdata !== mon_want.carrier || rsp_tuser !== mon_want.status) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("response %0d: expected carrier %02h status %0d, got %02h %0d",
                           rsp_seen, mon_want.carrier, mon_want.status, rsp_tdata, rsp_tuser);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      logic [7:0] cfg_values [6];
      cfg_values[0] = 8'hFF;
      cfg_values[1] = 8'($urandom_range(255));
      cfg_values[2] = 8'h00;
      cfg_values[3] = 8'($urandom_range(255));
      cfg_values[4] = 8'h01;
      cfg_values[5] = 8'hFE;
      send_idle_pct = 20;
      recv_idle_pct = 60;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, invalid adds, equal-mask tie, unused action, flush, full table.
      push_req(ACTION_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0);
      push_req(ACTION_ADD, '0, 32'hC0A8_0101, 32'hFFFF_FF00, 8'h11);
      push_req(ACTION_ADD, '0, 32'hC0A8_0200, 32'h0000_0000, 8'h05);
      push_req(ACTION_ADD, '0, 32'hC0A8_0000, 32'hFFFF_0000, 8'h00);
      push_req(ACTION_ADD, '0, 32'hC0A8_0100, 32'hFFFF_FF00, 8'h33);
      push_req(ACTION_LOOKUP, 32'hC0A8_01FF, '0, '0, '0);
      push_req(ACTION_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
      push_req(ACTION_FLUSH, '0, '0, '0, '0);
      for (int i = 0; i < PREFIX_ENTRIES; i++)
         push_req(ACTION_ADD, '0, 32'hFFFF_FFFF, prefix_mask(2 * i + 2), 8'(8'h80 + i));
      push_req(ACTION_ADD, '0, 32'hFFFF_FFFF, 32'h8000_0000, 8'hFF);
      push_req(ACTION_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0);
      push_req(ACTION_LOOKUP, 32'h0000_0000, '0, '0, '0);
      wait_idle();

      for (int ph = 0; ph < 6; ph++) begin
         write_miss_carrier(cfg_values[ph]);
         if (ph < 2) begin
            send_idle_pct = 20;
            recv_idle_pct = 60;
         end else if (ph < 4) begin
            send_idle_pct = 60;
            recv_idle_pct = 20;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (ph == 1 || ph == 4)
            hold_req++;
         pushed = 0;
         while (pushed < PHASE_ITEMS)
            gen_sequence();
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_rsp.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/cplt_pkg.sv
rtl/core/cplt_cell.sv
rtl/core/carrier_prefix_lpm_table.sv
rtl/core/cplt_checker.sv
dv/tb_top.sv
